// ----- rtl/u8dc_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dc_pkg: shared types and constants
// Item format passed from the decoder front to the classifier back, plus
// field widths and vowel class codes.
// ----------------------------------------------------------------------------
package u8dc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned VC_W    = 3;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [VC_W-1:0] {
		VC_NONE = 3'd0,
		VC_A    = 3'd1,
		VC_E    = 3'd2,
		VC_I    = 3'd3,
		VC_O    = 3'd4,
		VC_U    = 3'd5,
		VC_Y    = 3'd6
	} vowel_t;

	typedef struct packed {
		logic            point_valid;
		logic [CP_W-1:0] code_point;
		logic            in_word;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- rtl/u8dc_front.sv -----
// ----------------------------------------------------------------------------
// u8dc_front: UTF-8 sequence decoder
// Tracks the open sequence and gathers payload bits; emits one item per
// accepted byte, carrying the completed code point when there is one.
// ----------------------------------------------------------------------------
module u8dc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [u8dc_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          in_word,
	output u8dc_pkg::item_t               item
);

	logic [1:0]                  bytes_left_q;
	logic [1:0]                  bytes_left_n;
	logic [u8dc_pkg::CP_W-1:0]   acc_q;
	logic [u8dc_pkg::CP_W-1:0]   acc_n;

	always_comb begin
		bytes_left_n     = bytes_left_q;
		acc_n            = acc_q;
		item.point_valid = 1'b0;
		item.code_point  = '0;
		item.in_word     = in_word;
		if (bytes_left_q != 2'd0) begin
			acc_n        = {acc_q[u8dc_pkg::CP_W-7:0], in_byte[5:0]};
			bytes_left_n = bytes_left_q - 2'd1;
			if (bytes_left_n == 2'd0) begin
				item.point_valid = 1'b1;
				item.code_point  = acc_n;
			end
		end else if (!in_byte[7]) begin
			item.point_valid = 1'b1;
			item.code_point  = {{(u8dc_pkg::CP_W-8){1'b0}}, in_byte};
		end else if (in_byte[7:5] == 3'b110) begin
			bytes_left_n = 2'd1;
			acc_n        = {{(u8dc_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
		end else if (in_byte[7:4] == 4'b1110) begin
			bytes_left_n = 2'd2;
			acc_n        = {{(u8dc_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
		end else if (in_byte[7:3] == 5'b11110) begin
			bytes_left_n = 2'd3;
			acc_n        = {{(u8dc_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
		end
		// stray continuation and 0xF8+ leads fall through: dropped
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
		end else if (accept) begin
			bytes_left_q <= bytes_left_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_n;
		end
	end

endmodule

// ----- rtl/u8dc_queue.sv -----
// ----------------------------------------------------------------------------
// u8dc_queue: decoupling queue
// Small FIFO between decoder and classifier so each side stalls on its own.
// ----------------------------------------------------------------------------
module u8dc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  u8dc_pkg::q_ctrl_t ctrl,
	input  u8dc_pkg::item_t   wr_item,
	output u8dc_pkg::q_stat_t stat,
	output u8dc_pkg::item_t   rd_item
);

	u8dc_pkg::item_t                  mem_q [u8dc_pkg::Q_DEPTH];
	logic [u8dc_pkg::Q_PTR_W-1:0]     wr_ptr_q;
	logic [u8dc_pkg::Q_PTR_W-1:0]     rd_ptr_q;
	logic [u8dc_pkg::Q_CNT_W-1:0]     count_q;
	logic                             do_push;
	logic                             do_pop;

	assign stat.full  = (count_q == u8dc_pkg::Q_CNT_W'(u8dc_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = ctrl.push && !stat.full;
	assign do_pop     = ctrl.pop && !stat.empty;
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/u8dc_back.sv -----
// ----------------------------------------------------------------------------
// u8dc_back: code point classifier
// Classifies the queue head as separator, vowel class and word character
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module u8dc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  u8dc_pkg::item_t             head,
	input  logic                        head_valid,
	output logic                        head_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic                        point_valid,
	output logic [u8dc_pkg::CP_W-1:0]   code_point,
	output logic                        separator,
	output logic [u8dc_pkg::VC_W-1:0]   vowel_class,
	output logic                        word_char
);

	logic [u8dc_pkg::CP_W-1:0]   cp;
	logic [u8dc_pkg::CP_W-1:0]   f;
	logic                        sep_c;
	u8dc_pkg::vowel_t            vc_c;
	logic                        word_c;
	logic                        load;

	logic                        out_valid_q;
	logic                        point_valid_q;
	logic [u8dc_pkg::CP_W-1:0]   code_point_q;
	logic                        separator_q;
	u8dc_pkg::vowel_t            vowel_q;
	logic                        word_char_q;

	assign cp = head.point_valid ? head.code_point : '0;
	assign f  = (cp >= u8dc_pkg::CP_W'(8'hE0)) ? cp - u8dc_pkg::CP_W'(8'h20) : cp;

	always_comb begin
		sep_c = head.point_valid && (cp == u8dc_pkg::CP_W'(8'h20) || cp == u8dc_pkg::CP_W'(8'h09)
			|| cp == u8dc_pkg::CP_W'(8'h0A) || cp == u8dc_pkg::CP_W'(8'h0D));

		vc_c = u8dc_pkg::VC_NONE;
		if (f == 21'h61 || f == 21'h41 || (f >= 21'hC0 && f <= 21'hC3)) begin
			vc_c = u8dc_pkg::VC_A;
		end else if (f == 21'h65 || f == 21'h45 || (f >= 21'hC8 && f <= 21'hCA)) begin
			vc_c = u8dc_pkg::VC_E;
		end else if (f == 21'h69 || f == 21'h49 || (f >= 21'hCC && f <= 21'hCD)) begin
			vc_c = u8dc_pkg::VC_I;
		end else if (f == 21'h6F || f == 21'h4F || (f >= 21'hD2 && f <= 21'hD5)) begin
			vc_c = u8dc_pkg::VC_O;
		end else if (f == 21'h75 || f == 21'h55 || (f >= 21'hD9 && f <= 21'hDA)) begin
			vc_c = u8dc_pkg::VC_U;
		end else if (f == 21'h79 || f == 21'h59) begin
			vc_c = u8dc_pkg::VC_Y;
		end
		if (!head.point_valid) begin
			vc_c = u8dc_pkg::VC_NONE;
		end

		// typographic single quotes fold onto the apostrophe
		if (f == 21'h27 || f == 21'h1FF8 || f == 21'h1FF9) begin
			word_c = head.in_word;
		end else begin
			word_c = (f >= 21'h41 && f <= 21'h5A) || (f >= 21'h61 && f <= 21'h7A)
				|| (f >= 21'h30 && f <= 21'h39) || f == 21'hC7 || f == 21'h5F
				|| (f >= 21'hC0 && f <= 21'hC3) || (f >= 21'hC8 && f <= 21'hCA)
				|| (f >= 21'hCC && f <= 21'hCD) || (f >= 21'hD2 && f <= 21'hD5)
				|| (f >= 21'hD9 && f <= 21'hDA);
		end
		word_c = word_c && head.point_valid;
	end

	assign load     = head_valid && (!out_valid_q || pop);
	assign head_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			point_valid_q <= head.point_valid;
			code_point_q  <= cp;
			separator_q   <= sep_c;
			vowel_q       <= vc_c;
			word_char_q   <= word_c;
		end
	end

	assign empty       = !out_valid_q;
	assign point_valid = point_valid_q;
	assign code_point  = code_point_q;
	assign separator   = separator_q;
	assign vowel_class = vowel_q;
	assign word_char   = word_char_q;

endmodule

// ----- rtl/utf8_decode_and_classify.sv -----
// ----------------------------------------------------------------------------
// utf8_decode_and_classify: UTF-8 decoder with character classifier
// Decodes a byte stream into code points and classifies each completed point.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while full is low, and every byte yields
// exactly one result, in order. With nothing waiting ahead of it, a byte's
// item is written into the four-entry queue at the edge that takes the byte,
// and the classifier loads it into the output register at the next.
// Push may stay high continuously; full only rises when the result side stops
// popping and the queue plus output register (five transactions) are
// occupied. Bytes 0x80..0xBF outside a sequence and leads 0xF8..0xFF are
// dropped with point_valid low; any byte inside an open sequence is taken as a
// continuation.
module utf8_decode_and_classify (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [u8dc_pkg::BYTE_W-1:0] in_byte,
	input  logic                        in_word,
	output logic                        empty,
	input  logic                        pop,
	output logic                        point_valid,
	output logic [u8dc_pkg::CP_W-1:0]   code_point,
	output logic                        separator,
	output logic [u8dc_pkg::VC_W-1:0]   vowel_class,
	output logic                        word_char
);

	u8dc_pkg::item_t   front_item;
	u8dc_pkg::item_t   head_item;
	u8dc_pkg::q_ctrl_t q_ctrl;
	u8dc_pkg::q_stat_t q_stat;
	logic              accept;
	logic              head_pop;

	assign full        = q_stat.full;
	assign accept      = push && !q_stat.full;
	assign q_ctrl.push = accept;
	assign q_ctrl.pop  = head_pop;

	u8dc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_word (in_word),
		.item    (front_item)
	);

	u8dc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (q_ctrl),
		.wr_item (front_item),
		.stat    (q_stat),
		.rd_item (head_item)
	);

	u8dc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_item),
		.head_valid  (!q_stat.empty),
		.head_pop    (head_pop),
		.pop         (pop),
		.empty       (empty),
		.point_valid (point_valid),
		.code_point  (code_point),
		.separator   (separator),
		.vowel_class (vowel_class),
		.word_char   (word_char)
	);

	a_zero_when_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !point_valid) |-> (code_point == '0 && !separator
			&& vowel_class == u8dc_pkg::VC_NONE && !word_char))
		else $error("result fields not cleared without a code point");

	a_vowel_is_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && vowel_class != u8dc_pkg::VC_NONE) |-> word_char)
		else $error("vowel not classified as word character");

	a_sep_not_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && separator) |-> (!word_char && vowel_class == u8dc_pkg::VC_NONE))
		else $error("separator also classified as word or vowel");

	a_full_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while output register empty");

endmodule
